>>> hdl/pmm_pkg.sv
// ----------------------------------------------------------------------------
// Priority mutex manager package
// Sizes, command and status codes, shared types and priority encoders.
// ----------------------------------------------------------------------------
package pmm_pkg;

  localparam int MUTEX_COUNT = 8;
  localparam int TASK_COUNT  = 16;

  localparam int MIDX_W = $clog2(MUTEX_COUNT);
  localparam int TID_W  = $clog2(TASK_COUNT);
  // Task-to-mutex link also needs room for the empty code
  localparam int TM_W   = $clog2(MUTEX_COUNT + 1);

  localparam logic [TM_W-1:0] TM_EMPTY = TM_W'(MUTEX_COUNT);

  typedef enum logic [2:0] {
    CMD_TAKE   = 3'd0,
    CMD_GIVE   = 3'd1,
    CMD_CHECK  = 3'd2,
    CMD_UNLINK = 3'd3,
    CMD_CREATE = 3'd4,
    CMD_FREE   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NOT_AVAILABLE = 3'd1,
    ST_INVALID       = 3'd2,
    ST_NO_ROOM       = 3'd3,
    ST_NOT_OWNER     = 3'd4
  } status_t;

  // One wait-slot task write into the wait list store
  typedef struct packed {
    logic              en;
    logic [MIDX_W-1:0] row;
    logic [TID_W-1:0]  slot;
    logic [TID_W-1:0]  task_id;
  } slot_wr_t;

  typedef logic [TASK_COUNT-1:0][TID_W-1:0] slot_row_t;

  // Lowest-numbered set bit of a wait slot vector
  function automatic logic [TID_W-1:0] first_slot(input logic [TASK_COUNT-1:0] vec);
    logic [TID_W-1:0] idx;
    idx = '0;
    for (int i = TASK_COUNT - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = TID_W'(i);
      end
    end
    return idx;
  endfunction

  // Lowest-numbered clear bit of the in-use vector
  function automatic logic [MIDX_W-1:0] first_free(input logic [MUTEX_COUNT-1:0] vec);
    logic [MIDX_W-1:0] idx;
    idx = '0;
    for (int i = MUTEX_COUNT - 1; i >= 0; i--) begin
      if (!vec[i]) begin
        idx = MIDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> hdl/pmm_wait_store.sv
// ----------------------------------------------------------------------------
// Wait list task store
// One row per mutex, one task nibble per priority slot. Registered row read
// with a bypass for a slot written in the same cycle as the read.
// ----------------------------------------------------------------------------
module pmm_wait_store (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pmm_pkg::slot_wr_t                     wr,
  input  logic [pmm_pkg::MIDX_W-1:0]            rd_idx,
  output pmm_pkg::slot_row_t                    rd_row
);

  pmm_pkg::slot_row_t mem [pmm_pkg::MUTEX_COUNT];
  pmm_pkg::slot_row_t row_q;

  logic                         byp_hit;
  logic [pmm_pkg::TID_W-1:0]    byp_slot;
  logic [pmm_pkg::TID_W-1:0]    byp_task;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row][wr.slot] <= wr.task_id;
    end
    row_q    <= mem[rd_idx];
    byp_slot <= wr.slot;
    byp_task <= wr.task_id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= wr.en && (wr.row == rd_idx);
    end
  end

  // Patch in the slot that the read missed
  always_comb begin
    rd_row = row_q;
    if (byp_hit) begin
      rd_row[byp_slot] = byp_task;
    end
  end

endmodule

>>> hdl/priority_mutex_manager_core.sv
// ----------------------------------------------------------------------------
// Priority mutex manager core
// Pipeline: a command goes into the input register, then through one pass of
//   logic into the result register, where done marks the result.
// Throughput: one command per cycle; busy stays low, the receiver cannot stall.
// Reset: every mutex in use and unlocked, no waiters, every task unlinked.
// ----------------------------------------------------------------------------
module priority_mutex_manager_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  command,
  input  logic [2:0]                  mutex_index,
  input  logic [3:0]                  task_id,
  input  logic [3:0]                  task_priority,
  output logic                        done,
  output logic [2:0]                  status,
  output logic [2:0]                  created_index,
  output logic                        available,
  output logic                        wake_valid,
  output logic [3:0]                  wake_task_id
);

  localparam int MC     = pmm_pkg::MUTEX_COUNT;
  localparam int TC     = pmm_pkg::TASK_COUNT;
  localparam int MIDX_W = pmm_pkg::MIDX_W;
  localparam int TID_W  = pmm_pkg::TID_W;
  localparam int TM_W   = pmm_pkg::TM_W;

  // Mutex table and task links
  logic [MC-1:0]             created;
  logic [MC-1:0]             locked;
  logic [TID_W-1:0]          owner      [MC];
  logic [TC-1:0]             slot_valid [MC];
  logic [TM_W-1:0]           task_mutex [TC];

  // Input register
  logic                      in_valid;
  logic [2:0]                cmd_q;
  logic [MIDX_W-1:0]         m_q;
  logic [TID_W-1:0]          t_q;
  logic [TID_W-1:0]          p_q;
  logic [TM_W-1:0]           tm_q;

  // Pass logic
  logic                      use_m;
  logic [MIDX_W-1:0]         ma;
  logic                      usable;
  logic                      is_owner;
  logic [TC-1:0]             vs;
  pmm_pkg::slot_row_t        row;
  logic                      any_free;
  logic [MIDX_W-1:0]         free_idx;

  logic                      mx_we;
  logic [MIDX_W-1:0]         mx_idx;
  logic                      created_d;
  logic                      locked_d;
  logic [TID_W-1:0]          owner_d;
  logic                      slot_set;
  logic                      slot_clr;
  logic                      tm_we;
  logic [TM_W-1:0]           tm_d;
  logic [TM_W-1:0]           tm_fwd;
  pmm_pkg::slot_wr_t         slot_wr;

  pmm_pkg::status_t          status_next;
  logic [MIDX_W-1:0]         created_index_next;
  logic                      available_next;
  logic                      wake_valid_next;
  logic [TID_W-1:0]          wake_task_id_next;

  logic                      accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Link of the incoming task, as left by the command now in the pass
  assign tm_fwd = (tm_we && (t_q == task_id)) ? tm_d : task_mutex[task_id];

  pmm_wait_store u_store (
    .clk    (clk),
    .rst    (rst),
    .wr     (slot_wr),
    .rd_idx (tm_fwd[MIDX_W-1:0]),
    .rd_row (row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      m_q   <= mutex_index;
      t_q   <= task_id;
      p_q   <= task_priority;
      tm_q  <= tm_fwd;
    end
  end

  // Take and free name the mutex; give, check and unlink go through the task link
  assign use_m    = (cmd_q == pmm_pkg::CMD_TAKE) || (cmd_q == pmm_pkg::CMD_FREE);
  assign ma       = use_m ? m_q : tm_q[MIDX_W-1:0];
  assign usable   = (use_m || (tm_q < pmm_pkg::TM_EMPTY)) && created[ma];
  assign is_owner = locked[ma] && (owner[ma] == t_q);
  assign vs       = slot_valid[ma];
  assign any_free = !(&created);
  assign free_idx = pmm_pkg::first_free(created);

  // Task ids and priorities are full-width fields, so always in range
  always_comb begin
    status_next        = pmm_pkg::ST_OK;
    created_index_next = '0;
    available_next     = 1'b0;
    wake_valid_next    = 1'b0;
    wake_task_id_next  = '0;
    mx_we              = 1'b0;
    mx_idx             = ma;
    created_d          = created[ma];
    locked_d           = locked[ma];
    owner_d            = owner[ma];
    slot_set           = 1'b0;
    slot_clr           = 1'b0;
    tm_we              = 1'b0;
    tm_d               = pmm_pkg::TM_EMPTY;
    case (cmd_q)
      pmm_pkg::CMD_TAKE: begin
        if (!usable) begin
          status_next = pmm_pkg::ST_INVALID;
        end else if (locked[ma]) begin
          status_next = pmm_pkg::ST_NOT_AVAILABLE;
          if (owner[ma] != t_q) begin
            slot_set = 1'b1;
            tm_we    = 1'b1;
            tm_d     = TM_W'(m_q);
          end
        end else begin
          mx_we    = 1'b1;
          locked_d = 1'b1;
          owner_d  = t_q;
          slot_clr = 1'b1;
          tm_we    = 1'b1;
          tm_d     = TM_W'(m_q);
        end
      end
      pmm_pkg::CMD_GIVE: begin
        if (!usable) begin
          status_next = pmm_pkg::ST_INVALID;
        end else if (!is_owner) begin
          status_next = pmm_pkg::ST_NOT_OWNER;
        end else begin
          mx_we             = 1'b1;
          locked_d          = 1'b0;
          owner_d           = '0;
          tm_we             = 1'b1;
          wake_valid_next   = |vs;
          wake_task_id_next = (|vs) ? row[pmm_pkg::first_slot(vs)] : '0;
        end
      end
      pmm_pkg::CMD_CHECK: begin
        available_next = usable && !locked[ma];
      end
      pmm_pkg::CMD_UNLINK: begin
        if (!usable) begin
          status_next = pmm_pkg::ST_INVALID;
        end else begin
          // Wake is picked before this task's slot is dropped
          if (is_owner) begin
            mx_we             = 1'b1;
            locked_d          = 1'b0;
            owner_d           = '0;
            wake_valid_next   = |vs;
            wake_task_id_next = (|vs) ? row[pmm_pkg::first_slot(vs)] : '0;
          end
          tm_we    = 1'b1;
          slot_clr = 1'b1;
        end
      end
      pmm_pkg::CMD_CREATE: begin
        if (any_free) begin
          mx_we              = 1'b1;
          mx_idx             = free_idx;
          created_d          = 1'b1;
          locked_d           = 1'b0;
          owner_d            = '0;
          created_index_next = free_idx;
        end else begin
          status_next = pmm_pkg::ST_NO_ROOM;
        end
      end
      pmm_pkg::CMD_FREE: begin
        if (!usable) begin
          status_next = pmm_pkg::ST_INVALID;
        end else begin
          mx_we     = 1'b1;
          created_d = 1'b0;
        end
      end
      default: begin
        status_next = pmm_pkg::ST_INVALID;
      end
    endcase
    if (!in_valid) begin
      mx_we    = 1'b0;
      slot_set = 1'b0;
      slot_clr = 1'b0;
      tm_we    = 1'b0;
    end
  end

  always_comb begin
    slot_wr.en      = slot_set;
    slot_wr.row     = ma;
    slot_wr.slot    = p_q;
    slot_wr.task_id = t_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      created <= '1;
      locked  <= '0;
      for (int i = 0; i < MC; i++) begin
        owner[i]      <= '0;
        slot_valid[i] <= '0;
      end
      for (int i = 0; i < TC; i++) begin
        task_mutex[i] <= pmm_pkg::TM_EMPTY;
      end
    end else begin
      if (mx_we) begin
        created[mx_idx] <= created_d;
        locked[mx_idx]  <= locked_d;
        owner[mx_idx]   <= owner_d;
      end
      if (slot_set) begin
        slot_valid[ma][p_q] <= 1'b1;
      end else if (slot_clr) begin
        slot_valid[ma][p_q] <= 1'b0;
      end
      if (tm_we) begin
        task_mutex[t_q] <= tm_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    status        <= status_next;
    created_index <= created_index_next;
    available     <= available_next;
    wake_valid    <= wake_valid_next;
    wake_task_id  <= wake_task_id_next;
  end

endmodule
